/* rtl/ebcpu_pkg.sv */
`timescale 1ns / 1ps

package ebcpu_pkg;

	localparam int ROM_BYTES    = 16384;
	localparam int VIDEO_BYTES  = 8192;
	localparam int EXT_BYTES    = 8192;
	localparam int WORK_BYTES   = 8192;
	localparam int OBJECT_BYTES = 256;
	localparam int IO_BYTES     = 128;
	localparam int HIGH_SLOTS   = 128;

	localparam logic [1:0] ACT_EXEC  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [7:0] OP_RLCA    = 8'h07;
	localparam logic [7:0] OP_LD_NN_SP = 8'h08;
	localparam logic [7:0] OP_RRCA    = 8'h0F;
	localparam logic [7:0] OP_RLA     = 8'h17;
	localparam logic [7:0] OP_JR      = 8'h18;
	localparam logic [7:0] OP_RRA     = 8'h1F;
	localparam logic [7:0] OP_JR_NZ   = 8'h20;
	localparam logic [7:0] OP_JR_Z    = 8'h28;
	localparam logic [7:0] OP_CPL     = 8'h2F;
	localparam logic [7:0] OP_JR_NC   = 8'h30;
	localparam logic [7:0] OP_INC_HLM = 8'h34;
	localparam logic [7:0] OP_DEC_HLM = 8'h35;
	localparam logic [7:0] OP_SCF     = 8'h37;
	localparam logic [7:0] OP_JR_C    = 8'h38;
	localparam logic [7:0] OP_CCF     = 8'h3F;
	localparam logic [7:0] OP_HALT    = 8'h76;

	localparam logic [2:0] R_MEM = 3'd6;
	localparam logic [2:0] R_A   = 3'd7;
	localparam logic [1:0] P_HL  = 2'd2;
	localparam logic [1:0] P_SP  = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
	} in_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  reg_a;
		logic [7:0]  reg_flags;
		logic [15:0] reg_bc;
		logic [15:0] reg_de;
		logic [15:0] reg_hl;
		logic [15:0] reg_sp;
		logic [15:0] reg_pc;
	} out_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_BWR, S_BRD_A, S_BRD_D, S_OP_A, S_OP_D, S_IM1_A,
		S_IM1_D, S_IM2_A, S_IM2_D, S_MR_A, S_MR_D, S_EXEC, S_WR2, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		RG_ROM, RG_VID, RG_EXT, RG_WRK, RG_OBJ, RG_IO, RG_HIGH, RG_IE, RG_NONE
	} region_t;

	function automatic region_t decode_region(input logic [15:0] a);
		region_t r;
		if (a == 16'hFFFF)       r = RG_IE;
		else if (a >= 16'hFF80) r = RG_HIGH;
		else if (a >= 16'hFF00) r = RG_IO;
		else if (a >= 16'hFEA0) r = RG_NONE;
		else if (a >= 16'hFE00) r = RG_OBJ;
		else if (a >= 16'hC000) r = RG_WRK;
		else if (a >= 16'hA000) r = RG_EXT;
		else if (a >= 16'h8000) r = RG_VID;
		else if (a >= 16'h4000) r = RG_NONE;
		else                    r = RG_ROM;
		return r;
	endfunction

endpackage

/* rtl/eight_bit_cpu_step_with_memory_map.sv */
`timescale 1ns / 1ps
// 8-bit accumulator CPU step engine with a built-in 16-bit memory map.
// Command channel: an item (cmd) is taken at a clock edge with start high and
// busy low. action selects execute one instruction, write one bus byte or
// read one bus byte. Exactly one result beat follows each item: result is
// valid for the single cycle in which done is high; the receiver cannot
// stall and must take it then. busy stays high from acceptance until done.
// A new item is taken no earlier than the edge after the done beat. All
// memory traffic (opcode fetch, up to two immediate bytes, one data read, up
// to two data writes) goes one byte per access through a single shared
// memory port; a read puts out its address in an address state and takes
// the registered memory data in a separate data state.
// The 8-bit and 16-bit arithmetic run through one shared 16-bit adder under
// the sequencer; the PC step and the second write address use their own.
// Reset clears the architectural registers, then a clearing pass zeroes
// every memory, one address per cycle; busy is high during that pass.

module eight_bit_cpu_step_with_memory_map (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ebcpu_pkg::in_t      cmd,
	output logic                done,
	output ebcpu_pkg::out_t     result
);

	ebcpu_pkg::state_t state_q, state_d;
	logic [13:0] clr_q;
	ebcpu_pkg::in_t cmd_q;
	logic [7:0]  op_q, lo_q, hi_q, dat_q, rd_q;
	logic [7:0]  acc_q, flags_q, ie_q;
	logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0] sp_q, pc_q;

	logic [7:0]  acc_n, flags_n, b_n, c_n, d_n, e_n, h_n, l_n;
	logic [15:0] sp_n, pc_n;
	logic        exec_we;
	logic [7:0]  exec_wd;

	logic [15:0] mem_addr;
	logic        mem_we;
	logic [7:0]  mem_wd;
	logic [7:0]  mem_rdata;
	ebcpu_pkg::region_t region, region_s1;
	logic        clearing;

	logic [7:0] rom_mem [ebcpu_pkg::ROM_BYTES];
	logic [7:0] vid_mem [ebcpu_pkg::VIDEO_BYTES];
	logic [7:0] ext_mem [ebcpu_pkg::EXT_BYTES];
	logic [7:0] wrk_mem [ebcpu_pkg::WORK_BYTES];
	logic [7:0] obj_mem [ebcpu_pkg::OBJECT_BYTES];
	logic [7:0] io_mem  [ebcpu_pkg::IO_BYTES];
	logic [7:0] hi_mem  [ebcpu_pkg::HIGH_SLOTS];
	logic [7:0] rom_rd_s1, vid_rd_s1, ext_rd_s1, wrk_rd_s1, obj_rd_s1, io_rd_s1, hi_rd_s1;

	logic [13:0] rom_idx;
	logic [12:0] vid_idx;
	logic [7:0]  obj_idx;
	logic [6:0]  io_idx;
	logic [7:0]  clr_wd;

	logic [7:0]  op_d;
	logic        need_mr;
	logic [1:0]  n_imm;

	logic [15:0] bc, de, hl, ea, imm;
	logic [15:0] alu_a, alu_b;
	logic [16:0] alu_sum;

	logic        wr8_en, wp_en;
	logic [2:0]  wr8_k;
	logic [7:0]  wr8_v, v8, src8;
	logic [1:0]  wp_p;
	logic [15:0] wp_v;
	logic        take;

	assign bc  = {b_q, c_q};
	assign de  = {d_q, e_q};
	assign hl  = {h_q, l_q};
	assign imm = {hi_q, lo_q};
	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

	function automatic logic [15:0] pair_of(input logic [1:0] p, input logic [15:0] pbc,
		input logic [15:0] pde, input logic [15:0] phl, input logic [15:0] psp);
		logic [15:0] v;
		case (p)
			2'd0: v = pbc;
			2'd1: v = pde;
			2'd2: v = phl;
			default: v = psp;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] reg8(input logic [2:0] k, input logic [15:0] pbc,
		input logic [15:0] pde, input logic [15:0] phl, input logic [7:0] pmem,
		input logic [7:0] pacc);
		logic [7:0] v;
		case (k)
			3'd0: v = pbc[15:8];
			3'd1: v = pbc[7:0];
			3'd2: v = pde[15:8];
			3'd3: v = pde[7:0];
			3'd4: v = phl[15:8];
			3'd5: v = phl[7:0];
			3'd6: v = pmem;
			default: v = pacc;
		endcase
		return v;
	endfunction

	// decode
	assign op_d = (state_q == ebcpu_pkg::S_OP_D) ? mem_rdata : op_q;
	always_comb begin
		need_mr = 1'b0;
		n_imm   = 2'd0;
		if (op_d[7:6] == 2'b01 && op_d[2:0] == ebcpu_pkg::R_MEM && op_d != ebcpu_pkg::OP_HALT)
			need_mr = 1'b1;
		if (op_d == ebcpu_pkg::OP_INC_HLM || op_d == ebcpu_pkg::OP_DEC_HLM)
			need_mr = 1'b1;
		if (op_d[7:6] == 2'b00 && op_d[3:0] == 4'hA)
			need_mr = 1'b1;
		if (op_d[7:6] == 2'b00) begin
			if (op_d[2:0] == 3'd6 || op_d == ebcpu_pkg::OP_JR || op_d == ebcpu_pkg::OP_JR_NZ ||
				op_d == ebcpu_pkg::OP_JR_Z || op_d == ebcpu_pkg::OP_JR_NC ||
				op_d == ebcpu_pkg::OP_JR_C)
				n_imm = 2'd1;
			if (op_d[3:0] == 4'h1 || op_d == ebcpu_pkg::OP_LD_NN_SP)
				n_imm = 2'd2;
		end
	end

	assign ea = (op_q[7:6] == 2'b00 && op_q[2:0] == 3'd2 && !op_q[5]) ?
		pair_of(op_q[5:4], bc, de, hl, sp_q) : hl;

	// execute datapath around the shared adder
	always_comb begin
		acc_n = acc_q; flags_n = flags_q; sp_n = sp_q; pc_n = pc_q;
		b_n = b_q; c_n = c_q; d_n = d_q; e_n = e_q; h_n = h_q; l_n = l_q;
		alu_a = '0; alu_b = '0;
		wr8_en = 1'b0; wr8_k = op_q[5:3]; wr8_v = '0;
		wp_en = 1'b0; wp_p = op_q[5:4]; wp_v = '0;
		exec_we = 1'b0; exec_wd = '0;
		v8 = '0; take = 1'b0;
		src8 = reg8(op_q[2:0], bc, de, hl, dat_q, acc_q);
		if (op_q[7:6] == 2'b01) begin
			if (op_q != ebcpu_pkg::OP_HALT) begin
				wr8_en = 1'b1; wr8_v = src8;
			end
		end else if (op_q[7:6] == 2'b00) begin
			case (op_q[2:0])
				3'd4, 3'd5: begin
					alu_a = {8'h00, reg8(op_q[5:3], bc, de, hl, dat_q, acc_q)};
					alu_b = op_q[0] ? 16'hFFFF : 16'h0001;
					v8 = alu_sum[7:0];
					wr8_en = 1'b1; wr8_v = v8;
					if (op_q[0])
						flags_n = {v8 == 8'h00, 1'b1, v8[3:0] == 4'hF, flags_q[4], 4'h0};
					else
						flags_n = {v8 == 8'h00, 1'b0, v8[3:0] == 4'h0, flags_q[4], 4'h0};
				end
				3'd6: begin
					wr8_en = 1'b1; wr8_v = lo_q;
				end
				default: begin
					case (op_q[3:0])
						4'h1: begin
							wp_en = 1'b1; wp_v = imm;
						end
						4'h3, 4'hB: begin
							alu_a = pair_of(op_q[5:4], bc, de, hl, sp_q);
							alu_b = op_q[3] ? 16'hFFFF : 16'h0001;
							wp_en = 1'b1; wp_v = alu_sum[15:0];
						end
						4'h9: begin
							alu_a = hl;
							alu_b = pair_of(op_q[5:4], bc, de, hl, sp_q);
							wp_en = 1'b1; wp_p = ebcpu_pkg::P_HL; wp_v = alu_sum[15:0];
							flags_n = {flags_q[7], 1'b0, alu_sum[12] ^ alu_a[12] ^ alu_b[12],
								alu_sum[16], 4'h0};
						end
						4'h2, 4'hA: begin
							if (op_q[3]) acc_n = dat_q;
							else begin
								exec_we = 1'b1; exec_wd = acc_q;
							end
							alu_a = hl;
							alu_b = (op_q[5:4] == ebcpu_pkg::P_SP) ? 16'hFFFF : 16'h0001;
							if (op_q[5]) begin
								wp_en = 1'b1; wp_p = ebcpu_pkg::P_HL; wp_v = alu_sum[15:0];
							end
						end
						default: begin
							alu_a = pc_q;
							alu_b = {{8{lo_q[7]}}, lo_q};
							case (op_q)
								ebcpu_pkg::OP_RLCA: begin
									acc_n = {acc_q[6:0], acc_q[7]};
									flags_n = {3'b000, acc_q[7], 4'h0};
								end
								ebcpu_pkg::OP_RRCA: begin
									acc_n = {acc_q[0], acc_q[7:1]};
									flags_n = {3'b000, acc_q[0], 4'h0};
								end
								ebcpu_pkg::OP_RLA: begin
									acc_n = {acc_q[6:0], flags_q[4]};
									flags_n = {3'b000, acc_q[7], 4'h0};
								end
								ebcpu_pkg::OP_RRA: begin
									acc_n = {flags_q[4], acc_q[7:1]};
									flags_n = {3'b000, acc_q[0], 4'h0};
								end
								ebcpu_pkg::OP_LD_NN_SP: begin
									exec_we = 1'b1; exec_wd = sp_q[7:0];
								end
								ebcpu_pkg::OP_JR:    take = 1'b1;
								ebcpu_pkg::OP_JR_NZ: take = !flags_q[7];
								ebcpu_pkg::OP_JR_Z:  take = flags_q[7];
								ebcpu_pkg::OP_JR_NC: take = !flags_q[4];
								ebcpu_pkg::OP_JR_C:  take = flags_q[4];
								ebcpu_pkg::OP_CPL: begin
									acc_n = ~acc_q;
									flags_n = {flags_q[7], 1'b1, 1'b1, flags_q[4], 4'h0};
								end
								ebcpu_pkg::OP_SCF:
									flags_n = {flags_q[7], 1'b0, 1'b0, 1'b1, 4'h0};
								ebcpu_pkg::OP_CCF:
									flags_n = {flags_q[7], 1'b0, 1'b0, !flags_q[4], 4'h0};
								default: ;
							endcase
							if (take) pc_n = alu_sum[15:0];
						end
					endcase
				end
			endcase
		end
		if (wr8_en) begin
			case (wr8_k)
				3'd0: b_n = wr8_v;
				3'd1: c_n = wr8_v;
				3'd2: d_n = wr8_v;
				3'd3: e_n = wr8_v;
				3'd4: h_n = wr8_v;
				3'd5: l_n = wr8_v;
				ebcpu_pkg::R_MEM: begin
					exec_we = 1'b1; exec_wd = wr8_v;
				end
				default: acc_n = wr8_v;
			endcase
		end
		if (wp_en) begin
			case (wp_p)
				2'd0: {b_n, c_n} = wp_v;
				2'd1: {d_n, e_n} = wp_v;
				2'd2: {h_n, l_n} = wp_v;
				default: sp_n = wp_v;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ebcpu_pkg::S_CLR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		mem_addr = pc_q;
		mem_we   = 1'b0;
		mem_wd   = cmd_q.bus_data;
		unique case (state_q)
			ebcpu_pkg::S_CLR: if (clr_q == '1) state_d = ebcpu_pkg::S_IDLE;
			ebcpu_pkg::S_IDLE: begin
				if (start) begin
					case (cmd.action)
						ebcpu_pkg::ACT_EXEC:  state_d = ebcpu_pkg::S_OP_A;
						ebcpu_pkg::ACT_WRITE: state_d = ebcpu_pkg::S_BWR;
						ebcpu_pkg::ACT_READ:  state_d = ebcpu_pkg::S_BRD_A;
						default:              state_d = ebcpu_pkg::S_DONE;
					endcase
				end
			end
			ebcpu_pkg::S_BWR: begin
				mem_addr = cmd_q.bus_address; mem_we = 1'b1;
				state_d = ebcpu_pkg::S_DONE;
			end
			ebcpu_pkg::S_BRD_A: begin
				mem_addr = cmd_q.bus_address;
				state_d = ebcpu_pkg::S_BRD_D;
			end
			ebcpu_pkg::S_BRD_D: state_d = ebcpu_pkg::S_DONE;
			ebcpu_pkg::S_OP_A, ebcpu_pkg::S_IM1_A, ebcpu_pkg::S_IM2_A: begin
				mem_addr = pc_q;
				case (state_q)
					ebcpu_pkg::S_OP_A:  state_d = ebcpu_pkg::S_OP_D;
					ebcpu_pkg::S_IM1_A: state_d = ebcpu_pkg::S_IM1_D;
					default:            state_d = ebcpu_pkg::S_IM2_D;
				endcase
			end
			ebcpu_pkg::S_OP_D: begin
				if (op_d[7])          state_d = ebcpu_pkg::S_DONE;
				else if (n_imm != 0)  state_d = ebcpu_pkg::S_IM1_A;
				else if (need_mr)     state_d = ebcpu_pkg::S_MR_A;
				else                  state_d = ebcpu_pkg::S_EXEC;
			end
			ebcpu_pkg::S_IM1_D: begin
				if (n_imm == 2'd2)    state_d = ebcpu_pkg::S_IM2_A;
				else if (need_mr)     state_d = ebcpu_pkg::S_MR_A;
				else                  state_d = ebcpu_pkg::S_EXEC;
			end
			ebcpu_pkg::S_IM2_D: state_d = ebcpu_pkg::S_EXEC;
			ebcpu_pkg::S_MR_A: begin
				mem_addr = ea;
				state_d = ebcpu_pkg::S_MR_D;
			end
			ebcpu_pkg::S_MR_D: state_d = ebcpu_pkg::S_EXEC;
			ebcpu_pkg::S_EXEC: begin
				mem_addr = (op_q == ebcpu_pkg::OP_LD_NN_SP) ? imm : ea;
				mem_we = exec_we; mem_wd = exec_wd;
				state_d = (op_q == ebcpu_pkg::OP_LD_NN_SP) ? ebcpu_pkg::S_WR2 : ebcpu_pkg::S_DONE;
			end
			ebcpu_pkg::S_WR2: begin
				mem_addr = imm + 16'h0001; mem_we = 1'b1; mem_wd = sp_q[15:8];
				state_d = ebcpu_pkg::S_DONE;
			end
			ebcpu_pkg::S_DONE: state_d = ebcpu_pkg::S_IDLE;
			default: state_d = ebcpu_pkg::S_IDLE;
		endcase
	end

	// architectural and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0; acc_q <= '0; flags_q <= '0; ie_q <= '0;
			b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
			sp_q <= '0; pc_q <= '0; rd_q <= '0;
		end else begin
			if (clearing) clr_q <= clr_q + 14'd1;
			if (state_q == ebcpu_pkg::S_IDLE && start) rd_q <= '0;
			if (state_q == ebcpu_pkg::S_BRD_D) rd_q <= mem_rdata;
			if (state_q == ebcpu_pkg::S_OP_A || state_q == ebcpu_pkg::S_IM1_A ||
				state_q == ebcpu_pkg::S_IM2_A)
				pc_q <= pc_q + 16'h0001;
			if (mem_we && region == ebcpu_pkg::RG_IE) ie_q <= mem_wd;
			if (state_q == ebcpu_pkg::S_EXEC) begin
				acc_q <= acc_n; flags_q <= flags_n & 8'hF0; sp_q <= sp_n; pc_q <= pc_n;
				b_q <= b_n; c_q <= c_n; d_q <= d_n; e_q <= e_n; h_q <= h_n; l_q <= l_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ebcpu_pkg::S_IDLE && start) cmd_q <= cmd;
		if (state_q == ebcpu_pkg::S_OP_D)  op_q  <= mem_rdata;
		if (state_q == ebcpu_pkg::S_IM1_D) lo_q  <= mem_rdata;
		if (state_q == ebcpu_pkg::S_IM2_D) hi_q  <= mem_rdata;
		if (state_q == ebcpu_pkg::S_MR_D)  dat_q <= mem_rdata;
	end

	// memory map
	assign clearing = (state_q == ebcpu_pkg::S_CLR);
	assign region   = ebcpu_pkg::decode_region(mem_addr);
	assign rom_idx  = clearing ? clr_q : mem_addr[13:0];
	assign vid_idx  = clearing ? clr_q[12:0] : mem_addr[12:0];
	assign obj_idx  = clearing ? clr_q[7:0] : mem_addr[7:0];
	assign io_idx   = clearing ? clr_q[6:0] : mem_addr[6:0];
	assign clr_wd   = clearing ? 8'h00 : mem_wd;

	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_ROM)) rom_mem[rom_idx] <= clr_wd;
		rom_rd_s1 <= rom_mem[rom_idx];
	end
	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_VID)) vid_mem[vid_idx] <= clr_wd;
		vid_rd_s1 <= vid_mem[vid_idx];
	end
	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_EXT)) ext_mem[vid_idx] <= clr_wd;
		ext_rd_s1 <= ext_mem[vid_idx];
	end
	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_WRK)) wrk_mem[vid_idx] <= clr_wd;
		wrk_rd_s1 <= wrk_mem[vid_idx];
	end
	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_OBJ)) obj_mem[obj_idx] <= clr_wd;
		obj_rd_s1 <= obj_mem[obj_idx];
	end
	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_IO)) io_mem[io_idx] <= clr_wd;
		io_rd_s1 <= io_mem[io_idx];
	end
	always_ff @(posedge clk) begin
		if (clearing || (mem_we && region == ebcpu_pkg::RG_HIGH)) hi_mem[io_idx] <= clr_wd;
		hi_rd_s1 <= hi_mem[io_idx];
	end
	always_ff @(posedge clk) region_s1 <= region;

	always_comb begin
		case (region_s1)
			ebcpu_pkg::RG_ROM:  mem_rdata = rom_rd_s1;
			ebcpu_pkg::RG_VID:  mem_rdata = vid_rd_s1;
			ebcpu_pkg::RG_EXT:  mem_rdata = ext_rd_s1;
			ebcpu_pkg::RG_WRK:  mem_rdata = wrk_rd_s1;
			ebcpu_pkg::RG_OBJ:  mem_rdata = obj_rd_s1;
			ebcpu_pkg::RG_IO:   mem_rdata = io_rd_s1;
			ebcpu_pkg::RG_HIGH: mem_rdata = hi_rd_s1;
			ebcpu_pkg::RG_IE:   mem_rdata = ie_q;
			default:            mem_rdata = 8'h00;
		endcase
	end

	// result
	assign busy = (state_q != ebcpu_pkg::S_IDLE);
	assign done = (state_q == ebcpu_pkg::S_DONE);
	assign result.read_data = rd_q;
	assign result.reg_a     = acc_q;
	assign result.reg_flags = flags_q & 8'hF0;
	assign result.reg_bc    = bc;
	assign result.reg_de    = de;
	assign result.reg_hl    = hl;
	assign result.reg_sp    = sp_q;
	assign result.reg_pc    = pc_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("done not followed by idle");
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done && !mem_we) else $error("beat or write during clear");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start)) else $error("done without work");
	a_flags_low: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q[3:0] == 4'h0) else $error("flag low nibble set");

endmodule
